// File: rtl/lbbs_pkg.sv
`timescale 1ns / 1ps
package lbbs_pkg;

  localparam int LUMA_W     = 8;
  localparam int SUM_W      = 30;
  localparam int CNT_W      = 23;
  localparam int NUM_PAIRS  = 4;
  localparam int BLK8_LOG   = 3;
  localparam int BLK16_LOG  = 4;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 12;
  localparam int OUT_USER_W = 2;
  localparam int PAYLOAD_W  = 2 * SUM_W + 2 * CNT_W;
  localparam int TDATA_W    = ((PAYLOAD_W + 7) / 8) * 8;
  localparam int PAD_W      = TDATA_W - PAYLOAD_W;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W     = 2;

  localparam logic [SUM_W-1:0] SUM_MAX = '1;
  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  localparam logic [CFG_DATA_W-1:0] WIDTH_RESET  = 12'd320;
  localparam logic [CFG_DATA_W-1:0] HEIGHT_RESET = 12'd240;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

  // result order: direction in bit 1, block size in bit 0
  localparam logic [1:0] PAIR_H8  = 2'd0;
  localparam logic [1:0] PAIR_H16 = 2'd1;
  localparam logic [1:0] PAIR_V8  = 2'd2;
  localparam logic [1:0] PAIR_V16 = 2'd3;

  // bnd[k] set: difference of pair k lies across a block boundary
  typedef struct packed {
    logic [LUMA_W-1:0] dh;
    logic [LUMA_W-1:0] dv;
    logic              h_en;
    logic              v_en;
    logic [NUM_PAIRS-1:0] bnd;
    logic              last;
  } diff_item_t;

  typedef struct packed {
    logic [CNT_W-1:0] int_cnt;
    logic [SUM_W-1:0] int_sum;
    logic [CNT_W-1:0] bnd_cnt;
    logic [SUM_W-1:0] bnd_sum;
  } pair_stats_t;

  function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] a,
                                               input logic [LUMA_W-1:0] d);
    logic [SUM_W:0] s;
    s = {1'b0, a} + {{(SUM_W - LUMA_W + 1){1'b0}}, d};
    return s[SUM_W] ? SUM_MAX : s[SUM_W-1:0];
  endfunction

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] a);
    return (a == CNT_MAX) ? a : a + CNT_W'(1);
  endfunction

endpackage

// File: rtl/luma_block_boundary_stats_unit.sv
`timescale 1ns / 1ps
// Throughput: one luma sample per cycle while the queue has room; the four
//   results of a frame leave back to back when out_tready stays high.
// Path: the first result becomes valid once the frame's last sample has passed
//   the front register, the 4-deep queue and the snapshot into the result registers.
// Reset: 320x240 frame, positions and all sums and counts cleared; the line
//   store is not cleared and needs no clearing pass.
module luma_block_boundary_stats_unit #(
  parameter int MAX_LINE  = 2048,
  parameter int MAX_LINES = 2048
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [lbbs_pkg::LUMA_W-1:0]     in_tdata,   // [7:0] luma
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // [29:0] boundary_sum, [52:30] boundary_count, [82:53] interior_sum,
  // [105:83] interior_count, [111:106] zero
  output logic [lbbs_pkg::TDATA_W-1:0]    out_tdata,
  output logic [lbbs_pkg::OUT_USER_W-1:0] out_tuser,  // [0] direction, [1] block_size_code
  output logic                            out_tlast,  // last_of_frame
  input  logic                            cfg_we,
  input  logic [lbbs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lbbs_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import lbbs_pkg::*;

  logic       push_valid;
  diff_item_t push_item;
  logic       q_full;
  logic       q_valid;
  diff_item_t q_item;
  logic       q_ready;

  lbbs_front #(
    .MAX_LINE  (MAX_LINE),
    .MAX_LINES (MAX_LINES)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .push_valid (push_valid),
    .push_item  (push_item),
    .q_full     (q_full)
  );

  lbbs_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_item  (push_item),
    .q_full     (q_full),
    .pop_valid  (q_valid),
    .pop_item   (q_item),
    .pop_ready  (q_ready)
  );

  lbbs_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .restart    (cfg_we),
    .pop_valid  (q_valid),
    .pop_item   (q_item),
    .pop_ready  (q_ready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  // input stalls only on a full queue
  a_stall_on_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> q_full)
    else $error("input stalled while queue had room");

  // a result group is never cut short
  a_group_continues: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && !out_tlast) |=> out_tvalid)
    else $error("result group ended before its last transfer");

  // a new group starts only when a frame-end item is taken from the queue
  a_group_start: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && out_tlast && !(q_valid && q_ready && q_item.last))
      |=> !out_tvalid)
    else $error("result valid without a frame end");

endmodule

// File: rtl/lbbs_front.sv
`timescale 1ns / 1ps
module lbbs_front #(
  parameter int MAX_LINE  = 2048,
  parameter int MAX_LINES = 2048
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [lbbs_pkg::LUMA_W-1:0]         in_tdata,
  input  logic                                cfg_we,
  input  logic [lbbs_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [lbbs_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  output logic                                push_valid,
  output lbbs_pkg::diff_item_t                push_item,
  input  logic                                q_full
);
  import lbbs_pkg::*;

  localparam int CW = $clog2(MAX_LINE);
  localparam int RW = $clog2(MAX_LINES);

  function automatic logic [CW:0] clamp_w(input logic [CFG_DATA_W-1:0] v);
    logic [CW:0] res;
    if (int'(v) < 2) res = (CW+1)'(2);
    else if (int'(v) > MAX_LINE) res = (CW+1)'(MAX_LINE);
    else res = (CW+1)'(v);
    return res;
  endfunction

  function automatic logic [RW:0] clamp_h(input logic [CFG_DATA_W-1:0] v);
    logic [RW:0] res;
    if (int'(v) < 2) res = (RW+1)'(2);
    else if (int'(v) > MAX_LINES) res = (RW+1)'(MAX_LINES);
    else res = (RW+1)'(v);
    return res;
  endfunction

  function automatic logic [LUMA_W-1:0] absdiff(input logic [LUMA_W-1:0] a,
                                                input logic [LUMA_W-1:0] b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

  logic [CW:0]         width_lim_r;
  logic [RW:0]         height_lim_r;
  logic [CW-1:0]       col_r;
  logic [RW-1:0]       row_r;
  logic [LUMA_W-1:0]   left_r;
  logic [LUMA_W-1:0]   line_mem [MAX_LINE];
  logic [LUMA_W-1:0]   prev_rd_r;

  logic                s1_valid_r;
  logic [LUMA_W-1:0]   s1_luma_r;
  logic [LUMA_W-1:0]   s1_left_r;
  logic                s1_h_en_r;
  logic                s1_v_en_r;
  logic [NUM_PAIRS-1:0] s1_bnd_r;
  logic                s1_last_r;

  logic accept;
  logic end_line;
  logic end_frame;

  assign in_tready = !s1_valid_r || !q_full;
  assign accept    = in_tvalid && in_tready;
  assign end_line  = ({1'b0, col_r} + (CW+1)'(1)) >= width_lim_r;
  assign end_frame = end_line && (({1'b0, row_r} + (RW+1)'(1)) >= height_lim_r);

  // config writes also restart the frame
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_lim_r  <= clamp_w(WIDTH_RESET);
      height_lim_r <= clamp_h(HEIGHT_RESET);
      col_r        <= '0;
      row_r        <= '0;
      left_r       <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FRAME_WIDTH:  width_lim_r  <= clamp_w(cfg_wdata);
        REG_FRAME_HEIGHT: height_lim_r <= clamp_h(cfg_wdata);
        default: ;
      endcase
      col_r  <= '0;
      row_r  <= '0;
      left_r <= '0;
    end else if (accept) begin
      if (end_frame) begin
        col_r  <= '0;
        row_r  <= '0;
        left_r <= '0;
      end else if (end_line) begin
        col_r  <= '0;
        row_r  <= row_r + RW'(1);
        left_r <= in_tdata;
      end else begin
        col_r  <= col_r + CW'(1);
        left_r <= in_tdata;
      end
    end
  end

  // read-first: the sample above comes out while this row's sample goes in
  always_ff @(posedge clk) begin
    if (accept) begin
      prev_rd_r       <= line_mem[col_r];
      line_mem[col_r] <= in_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (accept) begin
      s1_valid_r <= 1'b1;
    end else if (!q_full) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_luma_r <= in_tdata;
      s1_left_r <= left_r;
      s1_v_en_r <= (row_r != '0);
      s1_h_en_r <= (row_r != '0) && (col_r != '0);
      s1_bnd_r  <= {row_r[BLK16_LOG-1:0] == '0, row_r[BLK8_LOG-1:0] == '0,
                    col_r[BLK16_LOG-1:0] == '0, col_r[BLK8_LOG-1:0] == '0};
      s1_last_r <= end_frame;
    end
  end

  assign push_valid     = s1_valid_r && !q_full;
  assign push_item.dh   = absdiff(s1_luma_r, s1_left_r);
  assign push_item.dv   = absdiff(s1_luma_r, prev_rd_r);
  assign push_item.h_en = s1_h_en_r;
  assign push_item.v_en = s1_v_en_r;
  assign push_item.bnd  = s1_bnd_r;
  assign push_item.last = s1_last_r;

endmodule

// File: rtl/lbbs_queue.sv
`timescale 1ns / 1ps
module lbbs_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push_valid,
  input  lbbs_pkg::diff_item_t push_item,
  output logic                 q_full,
  output logic                 pop_valid,
  output lbbs_pkg::diff_item_t pop_item,
  input  logic                 pop_ready
);
  import lbbs_pkg::*;

  diff_item_t          slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r;
  logic [QPTR_W-1:0]   rd_ptr_r;
  logic [QPTR_W:0]     count_r;
  logic                pop;

  assign q_full    = (count_r == (QPTR_W+1)'(QUEUE_DEPTH));
  assign pop_valid = (count_r != '0);
  assign pop_item  = slot_r[rd_ptr_r];
  assign pop       = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push_valid) slot_r[wr_ptr_r] <= push_item;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push_valid) wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      if (pop)        rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      case ({push_valid, pop})
        2'b10:   count_r <= count_r + (QPTR_W+1)'(1);
        2'b01:   count_r <= count_r - (QPTR_W+1)'(1);
        default: ;
      endcase
    end
  end

endmodule

// File: rtl/lbbs_back.sv
`timescale 1ns / 1ps
module lbbs_back (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            restart,
  input  logic                            pop_valid,
  input  lbbs_pkg::diff_item_t            pop_item,
  output logic                            pop_ready,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [lbbs_pkg::TDATA_W-1:0]    out_tdata,
  output logic [lbbs_pkg::OUT_USER_W-1:0] out_tuser,
  output logic                            out_tlast
);
  import lbbs_pkg::*;

  pair_stats_t acc_r    [NUM_PAIRS];
  pair_stats_t acc_nxt  [NUM_PAIRS];
  pair_stats_t shadow_r [NUM_PAIRS];
  logic        busy_r;
  logic [1:0]  res_idx_r;
  logic        out_xfer;
  logic        last_xfer;
  logic        pop;
  logic        snap;
  pair_stats_t sel;

  assign out_xfer  = out_tvalid && out_tready;
  assign last_xfer = out_xfer && (res_idx_r == PAIR_V16);
  // frame-end item waits until the previous group of results is drained
  assign pop_ready = !pop_item.last || !busy_r || last_xfer;
  assign pop       = pop_valid && pop_ready;
  assign snap      = pop && pop_item.last;

  always_comb begin
    for (int k = 0; k < NUM_PAIRS; k++) begin
      acc_nxt[k] = acc_r[k];
      if (pop && ((k < int'(PAIR_V8)) ? pop_item.h_en : pop_item.v_en)) begin
        if (pop_item.bnd[k]) begin
          acc_nxt[k].bnd_sum = sat_add(acc_r[k].bnd_sum,
                                       (k < int'(PAIR_V8)) ? pop_item.dh : pop_item.dv);
          acc_nxt[k].bnd_cnt = sat_inc(acc_r[k].bnd_cnt);
        end else begin
          acc_nxt[k].int_sum = sat_add(acc_r[k].int_sum,
                                       (k < int'(PAIR_V8)) ? pop_item.dh : pop_item.dv);
          acc_nxt[k].int_cnt = sat_inc(acc_r[k].int_cnt);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || restart || snap) begin
      for (int k = 0; k < NUM_PAIRS; k++) acc_r[k] <= '0;
    end else begin
      for (int k = 0; k < NUM_PAIRS; k++) acc_r[k] <= acc_nxt[k];
    end
  end

  always_ff @(posedge clk) begin
    if (snap) begin
      for (int k = 0; k < NUM_PAIRS; k++) shadow_r[k] <= acc_nxt[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r    <= 1'b0;
      res_idx_r <= PAIR_H8;
    end else if (snap) begin
      busy_r    <= 1'b1;
      res_idx_r <= PAIR_H8;
    end else if (out_xfer) begin
      res_idx_r <= res_idx_r + 2'd1;
      if (res_idx_r == PAIR_V16) busy_r <= 1'b0;
    end
  end

  assign sel        = shadow_r[res_idx_r];
  assign out_tvalid = busy_r;
  assign out_tdata  = {{PAD_W{1'b0}}, sel};
  assign out_tuser  = {res_idx_r[0], res_idx_r[1]};
  assign out_tlast  = (res_idx_r == PAIR_V16);

endmodule

// File: bench/luma_block_boundary_stats_unit_tb.sv
`timescale 1ns / 1ps
module luma_block_boundary_stats_unit_tb;
  import lbbs_pkg::*;

  localparam int MAX_LINE       = 2048;
  localparam int MAX_LINES      = 2048;
  localparam int SUM_LIMIT      = (1 << SUM_W) - 1;
  localparam int CNT_LIMIT      = (1 << CNT_W) - 1;
  localparam int BCNT_LO        = SUM_W;
  localparam int ISUM_LO        = SUM_W + CNT_W;
  localparam int ICNT_LO        = 2 * SUM_W + CNT_W;
  localparam int SETTLE_CYCLES  = 12;
  localparam int IDLE_LIMIT     = 5000;
  localparam int HOLD_CYCLES    = 400;
  localparam int RANDOM_SAMPLES = 60;
  localparam int RANDOM_FRAMES  = 3;

  typedef enum int {PAT_NOISE, PAT_BLOCKS, PAT_BINARY, PAT_RAMP} image_pattern_e;

  typedef struct packed {
    logic             direction;
    logic             block_size;
    logic [SUM_W-1:0] bnd_sum;
    logic [CNT_W-1:0] bnd_cnt;
    logic [SUM_W-1:0] int_sum;
    logic [CNT_W-1:0] int_cnt;
    logic             last;
  } stat_result_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [LUMA_W-1:0]     in_tdata = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [TDATA_W-1:0]    out_tdata;
  logic [OUT_USER_W-1:0] out_tuser;
  logic                  out_tlast;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  luma_block_boundary_stats_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow of the block: registers, line store, positions, accumulators
  logic [CFG_DATA_W-1:0] shadow_width;
  logic [CFG_DATA_W-1:0] shadow_height;
  logic [LUMA_W-1:0]     line_mem [MAX_LINE];
  logic [LUMA_W-1:0]     left_luma;
  int unsigned           col_pos;
  int unsigned           row_pos;
  int unsigned           acc_sum [8];
  int unsigned           acc_cnt [8];

  logic [LUMA_W-1:0] pixel_queue [$];
  stat_result_t      expected_stats [$];

  int unsigned samples_accepted = 0;
  int unsigned frames_predicted = 0;
  int unsigned results_checked = 0;
  int unsigned reg_writes = 0;
  int unsigned mismatches = 0;
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;
  int unsigned hold_left = 0;
  int unsigned rx_mode_left = 0;
  int unsigned rx_mode = 0;
  int unsigned rx_tick = 0;
  int unsigned stall_cycles = 0;
  bit          hold_req = 1'b0;

  function automatic int unsigned clamp_dim(int unsigned v, int unsigned hi);
    if (v < 2) return 2;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic int unsigned absdiff(int unsigned a, int unsigned b);
    return (a > b) ? a - b : b - a;
  endfunction

  function automatic void clear_frame_stats();
    left_luma = '0;
    col_pos = 0;
    row_pos = 0;
    for (int i = 0; i < 8; i++) begin
      acc_sum[i] = 0;
      acc_cnt[i] = 0;
    end
  endfunction

  // accumulator slot: pair code in the upper bits, interior flag in bit 0
  function automatic void add_diff(logic [1:0] pair, bit interior, int unsigned d);
    int unsigned slot;
    slot = {pair, interior};
    acc_sum[slot] = (acc_sum[slot] + d > SUM_LIMIT) ? SUM_LIMIT : acc_sum[slot] + d;
    if (acc_cnt[slot] < CNT_LIMIT) acc_cnt[slot]++;
  endfunction

  task automatic predict_sample(input logic [LUMA_W-1:0] luma);
    int unsigned w;
    int unsigned h;
    int unsigned x;
    int unsigned r;
    int unsigned idx;
    int unsigned dv;
    int unsigned dh;
    logic [1:0]  pair;
    stat_result_t res;
    w = clamp_dim(shadow_width, MAX_LINE);
    h = clamp_dim(shadow_height, MAX_LINES);
    x = col_pos;
    r = row_pos;
    idx = (x < MAX_LINE) ? x : MAX_LINE - 1;
    if (r >= 1) begin
      dv = absdiff(luma, line_mem[idx]);
      add_diff(PAIR_V8, (r % 8) != 0, dv);
      add_diff(PAIR_V16, (r % 16) != 0, dv);
      if (x >= 1) begin
        dh = absdiff(luma, left_luma);
        add_diff(PAIR_H8, (x % 8) != 0, dh);
        add_diff(PAIR_H16, (x % 16) != 0, dh);
      end
    end
    line_mem[idx] = luma;
    left_luma = luma;
    if (x + 1 >= w && r + 1 >= h) begin
      for (int k = 0; k < NUM_PAIRS; k++) begin
        pair = k[1:0];
        res.direction  = pair[1];
        res.block_size = pair[0];
        res.bnd_sum    = acc_sum[2 * k][SUM_W-1:0];
        res.bnd_cnt    = acc_cnt[2 * k][CNT_W-1:0];
        res.int_sum    = acc_sum[2 * k + 1][SUM_W-1:0];
        res.int_cnt    = acc_cnt[2 * k + 1][CNT_W-1:0];
        res.last       = (pair == PAIR_V16);
        expected_stats.push_back(res);
      end
      frames_predicted++;
      clear_frame_stats();
    end else if (x + 1 >= w) begin
      col_pos = 0;
      row_pos = (r + 1) & 11'h7FF;
    end else begin
      col_pos = (x + 1) & 11'h7FF;
    end
  endtask

  task automatic check_field(string name, longint unsigned want, longint unsigned got);
    if (want != got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  // sender: bursts of random length separated by random gaps
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= '0;
    end else begin
      if (in_tvalid && in_tready) begin
        predict_sample(in_tdata);
        samples_accepted++;
      end
      if (!in_tvalid || in_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_tvalid <= 1'b0;
        end else if (pixel_queue.size() > 0) begin
          in_tvalid <= 1'b1;
          in_tdata  <= pixel_queue.pop_front();
          if (burst_left > 0) burst_left--;
          if (burst_left == 0) begin
            case ($urandom_range(0, 9))
              0, 1: begin
                burst_left = $urandom_range(100, 400);
                gap_left   = 0;
              end
              2: begin
                burst_left = $urandom_range(1, 8);
                gap_left   = $urandom_range(8, 30);
              end
              default: begin
                burst_left = $urandom_range(1, 24);
                gap_left   = $urandom_range(0, 4);
              end
            endcase
          end
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver: changing stall pattern, plus one long hold-off on request
  always @(posedge clk) begin
    rx_tick++;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_req) begin
      hold_req = 1'b0;
      hold_left = HOLD_CYCLES;
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      if (rx_mode_left == 0) begin
        rx_mode = $urandom_range(0, 3);
        rx_mode_left = $urandom_range(20, 200);
      end
      rx_mode_left--;
      case (rx_mode)
        0: out_tready <= 1'b1;
        1: out_tready <= $urandom_range(0, 1);
        2: out_tready <= ($urandom_range(0, 3) == 0);
        default: out_tready <= (rx_tick % 5) != 0;
      endcase
    end
  end

  always @(posedge clk) begin
    stat_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      results_checked++;
      if (expected_stats.size() == 0) begin
        mismatches++;
        $display("%0t: result transfer with nothing expected, tuser %0d tdata %h",
                 $time, out_tuser, out_tdata);
      end else begin
        want = expected_stats.pop_front();
        check_field("direction", want.direction, out_tuser[0]);
        check_field("block_size_code", want.block_size, out_tuser[1]);
        check_field("boundary_sum", want.bnd_sum, out_tdata[0 +: SUM_W]);
        check_field("boundary_count", want.bnd_cnt, out_tdata[BCNT_LO +: CNT_W]);
        check_field("interior_sum", want.int_sum, out_tdata[ISUM_LO +: SUM_W]);
        check_field("interior_count", want.int_cnt, out_tdata[ICNT_LO +: CNT_W]);
        check_field("tdata padding", 0, out_tdata[TDATA_W-1:PAYLOAD_W]);
        check_field("last_of_frame", want.last, out_tlast);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
    end
    if (stall_cycles == IDLE_LIMIT) begin
      $display("%0t: no transfer for %0d cycles, %0d results outstanding",
               $time, IDLE_LIMIT, expected_stats.size());
      $display("luma_block_boundary_stats_unit_tb failed");
      $finish;
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_FRAME_WIDTH) shadow_width = val;
    else shadow_height = val;
    clear_frame_stats();
    reg_writes++;
  endtask

  task automatic set_size(input logic [CFG_DATA_W-1:0] w, input logic [CFG_DATA_W-1:0] h);
    write_reg(REG_FRAME_WIDTH, w);
    write_reg(REG_FRAME_HEIGHT, h);
    @(negedge clk);
  endtask

  // idle means: every sample taken, every result out, and the pipe flushed
  task automatic drain();
    while (pixel_queue.size() != 0 || in_tvalid || expected_stats.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic queue_image(int unsigned w, int unsigned h, int unsigned count,
                             image_pattern_e pat);
    int unsigned seed;
    int unsigned pos;
    int unsigned x;
    int unsigned y;
    int unsigned v;
    seed = $urandom_range(0, 255);
    for (int unsigned p = 0; p < count; p++) begin
      pos = p % (w * h);
      x = pos % w;
      y = pos / w;
      case (pat)
        PAT_BLOCKS: v = (x / 8) * 53 + (y / 8) * 97 + seed + $urandom_range(0, 3);
        PAT_BINARY: v = $urandom_range(0, 1) ? 255 : 0;
        PAT_RAMP:   v = x * 5 + y * 3 + seed;
        default:    v = $urandom_range(0, 255);
      endcase
      pixel_queue.push_back(v[LUMA_W-1:0]);
    end
  endtask

  initial begin
    int unsigned w;
    int unsigned h;
    int unsigned frames;
    int unsigned count;
    int unsigned rand_samples;
    int unsigned rand_frames;
    logic [CFG_DATA_W-1:0] w_raw;
    logic [CFG_DATA_W-1:0] h_raw;

    shadow_width  = WIDTH_RESET;
    shadow_height = HEIGHT_RESET;
    clear_frame_stats();
    rand_samples = 0;
    rand_frames  = 0;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // part of a frame at the reset size; the next register write abandons it
    queue_image(clamp_dim(shadow_width, MAX_LINE), clamp_dim(shadow_height, MAX_LINES),
                24, PAT_BLOCKS);
    drain();

    // zero and one clamp up to 2x2; full-scale steps in both directions
    set_size(12'd0, 12'd1);
    pixel_queue = '{8'd0, 8'd255, 8'd255, 8'd0};
    drain();

    set_size(12'd3, 12'd3);
    pixel_queue = '{8'd255, 8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255};
    drain();

    // a register write in the middle of a frame starts a new one
    set_size(12'd5, 12'd4);
    pixel_queue = '{8'd17, 8'd200, 8'd0, 8'd255, 8'd128, 8'd1};
    drain();
    write_reg(REG_FRAME_HEIGHT, 12'd2);
    @(negedge clk);
    pixel_queue = '{8'd255, 8'd255, 8'd0, 8'd0, 8'd255,
                    8'd0, 8'd0, 8'd255, 8'd255, 8'd0};
    drain();

    // block boundaries at 8 and 16 along a row, then down a column
    set_size(12'd18, 12'd2);
    queue_image(18, 2, 36, PAT_RAMP);
    drain();
    set_size(12'd2, 12'd18);
    queue_image(2, 18, 36, PAT_BLOCKS);
    drain();

    // sizes above the clamp: no frame end within these samples
    set_size(12'd4095, 12'd2);
    queue_image(MAX_LINE, 2, 24, PAT_NOISE);
    drain();
    set_size(12'd2, 12'd4095);
    queue_image(2, MAX_LINES, 24, PAT_BINARY);
    drain();

    // tiny frames against a long output stall so the input backs up
    set_size(12'd2, 12'd2);
    hold_req = 1'b1;
    queue_image(2, 2, 48, PAT_NOISE);
    drain();

    while (rand_samples < RANDOM_SAMPLES || rand_frames < RANDOM_FRAMES) begin
      case ($urandom_range(0, 9))
        0: begin
          w_raw = $urandom_range(0, 1);
          h_raw = $urandom_range(0, 6);
        end
        1: begin
          w_raw = $urandom_range(17, 40);
          h_raw = $urandom_range(0, 3);
        end
        2: begin
          w_raw = $urandom_range(2, 12);
          h_raw = $urandom_range(0, 1);
        end
        default: begin
          w_raw = $urandom_range(2, 12);
          h_raw = $urandom_range(2, 8);
        end
      endcase
      case ($urandom_range(0, 2))
        0: write_reg(REG_FRAME_WIDTH, w_raw);
        1: write_reg(REG_FRAME_HEIGHT, h_raw);
        default: begin
          write_reg(REG_FRAME_HEIGHT, h_raw);
          write_reg(REG_FRAME_WIDTH, w_raw);
        end
      endcase
      @(negedge clk);
      w = clamp_dim(shadow_width, MAX_LINE);
      h = clamp_dim(shadow_height, MAX_LINES);
      frames = (w * h > 48) ? 1 : $urandom_range(1, 2);
      count = frames * w * h;
      // sometimes leave a partial frame for the next write to abandon
      if ($urandom_range(0, 3) == 0) count += $urandom_range(1, w * h - 1);
      queue_image(w, h, count, image_pattern_e'($urandom_range(0, 3)));
      rand_samples += count;
      rand_frames += frames;
      drain();
    end

    $display("covered %0d samples in %0d frames, %0d results checked, %0d register writes",
             samples_accepted, frames_predicted, results_checked, reg_writes);
    $display("small frames with 8 and 16 boundaries both ways, clamped sizes, %s",
             "mid-frame restarts and a long output stall");
    if (mismatches == 0) begin
      $display("luma_block_boundary_stats_unit_tb passed");
    end else begin
      $display("luma_block_boundary_stats_unit_tb failed");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/lbbs_pkg.sv
rtl/lbbs_front.sv
rtl/lbbs_queue.sv
rtl/lbbs_back.sv
rtl/luma_block_boundary_stats_unit.sv
bench/luma_block_boundary_stats_unit_tb.sv
